// ===== rtl/mi_pkg.sv =====
// Shared constants for the modular inverse block.
// Holds the default operand width and the result status codes.
// No dependencies.
package mi_pkg;

	localparam int MI_WIDTH = 31;

	localparam logic [1:0] STATUS_FOUND   = 2'd0;
	localparam logic [1:0] STATUS_MOD_ONE = 2'd1;
	localparam logic [1:0] STATUS_NONE    = 2'd2;
	localparam logic [1:0] STATUS_UNUSED  = 2'd3;

endpackage

// ===== rtl/mi_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Returns the remainder and the product of the quotient with a signed multiplicand.
// Depends on mi_pkg.
module mi_divider
	import mi_pkg::*;
#(
	parameter int WIDTH = MI_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [WIDTH-1:0]        dividend,
	input  logic [WIDTH-1:0]        divisor,
	input  logic signed [WIDTH+1:0] mult,
	output logic                    done,
	output logic [WIDTH-1:0]        rem,
	output logic signed [WIDTH+1:0] prod
);

	localparam int CW = $clog2(WIDTH);
	localparam int TW = WIDTH + 2;

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WIDTH-1:0]     rem_q;
	logic [WIDTH-1:0]     quo_q;
	logic [WIDTH-1:0]     dvs_q;
	logic signed [TW-1:0] mul_q;
	logic signed [TW-1:0] prod_q;

	logic [WIDTH:0]       shifted;
	logic [WIDTH:0]       diff;
	logic                 qbit;
	logic [WIDTH-1:0]     rem_next;
	logic signed [TW-1:0] prod_next;

	assign shifted   = {rem_q, quo_q[WIDTH-1]};
	assign diff      = shifted - {1'b0, dvs_q};
	assign qbit      = ~diff[WIDTH];
	assign rem_next  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	assign prod_next = (prod_q <<< 1) + (qbit ? mul_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q  <= rem_next;
			quo_q  <= {quo_q[WIDTH-2:0], qbit};
			prod_q <= prod_next;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			mul_q  <= mult;
			prod_q <= '0;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
	assign prod = prod_q;

endmodule

// ===== rtl/modular_inverse.sv =====
// Modular inverse by the extended Euclidean algorithm.
// Top level: input and output channels, step sequencer, coefficient tracking.
// Depends on mi_pkg and mi_divider.
//
// Usage:
//   Input transaction: value and modulus, taken when in_valid is high and
//   in_stall is low. Output transaction: inverse and status, taken when
//   out_valid is high and out_stall is low.
//   status: found (inverse in 0 .. modulus-1), modulus one, or no inverse
//   (modulus zero or value not coprime to modulus); inverse is 0 unless found.
//   One transaction is in work at a time; in_stall stays high from accept
//   until the result is loaded into the output register.
//   A modulus of zero or one goes from accept straight to S_EMIT, which
//   loads the output register once it is free. Otherwise the block runs one
//   reduction of value by modulus, then one division per Euclid step (at
//   most about 45 steps at WIDTH 31), all on the single bit-serial divider,
//   with S_CHECK after each; for a found inverse S_FIX and S_NORM then bring
//   the coefficient into range before S_EMIT.
//   A stalled result holds in the output register; the next input
//   transaction is accepted meanwhile and its result waits for the register.
//   Reset clears the sequencer and the output valid flag.
module modular_inverse
	import mi_pkg::*;
#(
	parameter int WIDTH = MI_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] inverse,
	output logic [1:0]       status
);

	localparam int TW = WIDTH + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_CHECK,
		S_DIV,
		S_FIX,
		S_NORM,
		S_EMIT
	} state_t;

	state_t               state_q;
	logic                 div_start_q;
	logic                 out_valid_q;
	logic [WIDTH-1:0]     m_q;
	logic [WIDTH-1:0]     r_prev_q;
	logic [WIDTH-1:0]     r_cur_q;
	logic signed [TW-1:0] t_prev_q;
	logic signed [TW-1:0] t_cur_q;
	logic [WIDTH-1:0]     res_inv_q;
	logic [1:0]           res_st_q;
	logic [WIDTH-1:0]     inverse_q;
	logic [1:0]           status_q;

	logic                 in_acc;
	logic                 out_free;
	logic [WIDTH-1:0]     dvd;
	logic [WIDTH-1:0]     dvs;
	logic                 div_done;
	logic [WIDTH-1:0]     div_rem;
	logic signed [TW-1:0] div_prod;
	logic signed [TW-1:0] m_ext;
	logic signed [TW-1:0] t_red;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign m_ext    = $signed({2'b00, m_q});
	assign t_red    = t_prev_q - m_ext;

	assign dvd = (state_q == S_RED) ? r_cur_q : r_prev_q;
	assign dvs = (state_q == S_RED) ? r_prev_q : r_cur_q;

	mi_divider #(
		.WIDTH(WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dvd),
		.divisor  (dvs),
		.mult     (t_cur_q),
		.done     (div_done),
		.rem      (div_rem),
		.prod     (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						m_q      <= modulus;
						r_prev_q <= modulus;
						r_cur_q  <= value;
						if (modulus == '0) begin
							res_st_q  <= STATUS_NONE;
							res_inv_q <= '0;
							state_q   <= S_EMIT;
						end else if (modulus == WIDTH'(1)) begin
							res_st_q  <= STATUS_MOD_ONE;
							res_inv_q <= '0;
							state_q   <= S_EMIT;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_RED;
						end
					end
				end
				S_RED: begin
					if (div_done) begin
						r_cur_q  <= div_rem;
						t_prev_q <= '0;
						t_cur_q  <= TW'(1);
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (r_cur_q != '0) begin
						div_start_q <= 1'b1;
						state_q     <= S_DIV;
					end else if (r_prev_q != WIDTH'(1)) begin
						res_st_q  <= STATUS_NONE;
						res_inv_q <= '0;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_FIX;
					end
				end
				S_DIV: begin
					if (div_done) begin
						r_prev_q <= r_cur_q;
						r_cur_q  <= div_rem;
						t_prev_q <= t_cur_q;
						t_cur_q  <= t_prev_q - div_prod;
						state_q  <= S_CHECK;
					end
				end
				S_FIX: begin
					if (t_prev_q[TW-1]) begin
						t_prev_q <= t_prev_q + m_ext;
					end
					state_q <= S_NORM;
				end
				S_NORM: begin
					res_st_q  <= STATUS_FOUND;
					res_inv_q <= t_red[TW-1] ? t_prev_q[WIDTH-1:0] : t_red[WIDTH-1:0];
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						inverse_q   <= res_inv_q;
						status_q    <= res_st_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign inverse   = inverse_q;
	assign status    = status_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input accepted but block not busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != STATUS_UNUSED))
		else $error("undefined status code");

	a_zero_when_failed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STATUS_FOUND) |-> (inverse == '0))
		else $error("nonzero inverse with failure status");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_RED || state_q == S_DIV))
		else $error("divider finished outside a division step");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM) |-> !t_prev_q[TW-1])
		else $error("coefficient still negative after fix-up");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for modular_inverse: directed and random value/modulus transactions,
// checked against an in-bench extended Euclid predictor. Depends on mi_pkg and the RTL.
module tb;
	import mi_pkg::*;

	localparam int          W        = MI_WIDTH;
	localparam logic [W-1:0] MAXV    = {W{1'b1}};
	localparam int          HOLDOFF  = 4000;
	localparam int          N_RANDOM = 400;

	typedef struct packed {
		logic [W-1:0] value;
		logic [W-1:0] modulus;
	} operand_pair_t;

	typedef struct packed {
		logic [W-1:0] inverse;
		logic [1:0]   status;
	} inv_result_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_stall;
	logic [W-1:0] value    = '0;
	logic [W-1:0] modulus  = '0;
	logic         out_valid;
	logic         out_stall = 1'b0;
	logic [W-1:0] inverse;
	logic [1:0]   status;

	operand_pair_t pairs_pending[$];
	inv_result_t   inverse_due[$];

	bit in_fire       = 1'b0;
	int accepted_cnt  = 0;
	int results_seen  = 0;
	int errors        = 0;
	int n_found       = 0;
	int n_mod_one     = 0;
	int n_none        = 0;
	int holdoff_left  = 0;
	bit holdoff_done  = 1'b0;

	modular_inverse u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.modulus   (modulus),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.inverse   (inverse),
		.status    (status)
	);

	always #5 clk = ~clk;

	function automatic inv_result_t predict_inverse(input logic [W-1:0] a,
			input logic [W-1:0] m);
		inv_result_t       res;
		longint unsigned   r_prev, r_cur, r_next, q, inv_full;
		longint            t_prev, t_cur, t_next;
		res.inverse = '0;
		res.status  = STATUS_FOUND;
		if (m == 0) begin
			res.status = STATUS_NONE;
		end else if (m == 1) begin
			res.status = STATUS_MOD_ONE;
		end else begin
			r_prev = m;
			r_cur  = a % m;
			t_prev = 0;
			t_cur  = 1;
			while (r_cur != 0) begin
				q      = r_prev / r_cur;
				r_next = r_prev - q * r_cur;
				t_next = t_prev - longint'(q) * t_cur;
				r_prev = r_cur;
				r_cur  = r_next;
				t_prev = t_cur;
				t_cur  = t_next;
			end
			if (r_prev != 1) begin
				res.status = STATUS_NONE;
			end else begin
				if (t_prev < 0)
					t_prev = t_prev + longint'(m);
				inv_full    = longint'(t_prev) % longint'(m);
				res.inverse = inv_full[W-1:0];
			end
		end
		return res;
	endfunction

	task automatic queue_pair(input logic [W-1:0] v, input logic [W-1:0] m);
		operand_pair_t p;
		p.value   = v;
		p.modulus = m;
		pairs_pending.push_back(p);
	endtask

	// driver: hold an offered transaction until taken, else pick the next one or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pairs_pending.size() == 0 ||
					(!(accepted_cnt >= 200 && accepted_cnt < 280) &&
					$urandom_range(99) < 6)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				value    <= pairs_pending[0].value;
				modulus  <= pairs_pending[0].modulus;
			end
		end
	end

	// receiver: one long hold-off, random stalls otherwise, none while results 150 to 229 are seen
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (holdoff_left != 0) begin
			out_stall    <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && results_seen >= 25) begin
			out_stall    <= 1'b1;
			holdoff_left <= HOLDOFF - 1;
			holdoff_done <= 1'b1;
		end else begin
			out_stall <= !(results_seen >= 150 && results_seen < 230) &&
				($urandom_range(99) < 6);
		end
	end

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		inv_result_t exp_res;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			exp_res = predict_inverse(pairs_pending[0].value, pairs_pending[0].modulus);
			void'(pairs_pending.pop_front());
			inverse_due.push_back(exp_res);
			accepted_cnt++;
			case (exp_res.status)
				STATUS_FOUND:   n_found++;
				STATUS_MOD_ONE: n_mod_one++;
				default:        n_none++;
			endcase
		end
	end

	// output side: compare against the oldest expectation
	always @(posedge clk) begin
		inv_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (inverse_due.size() == 0) begin
				if (errors < 10)
					$display("ERROR: unexpected result inverse=%0d status=%0d",
						inverse, status);
				errors++;
			end else begin
				exp_res = inverse_due.pop_front();
				if (inverse !== exp_res.inverse || status !== exp_res.status) begin
					if (errors < 10)
						$display("ERROR: result %0d expected inverse=%0d status=%0d, got inverse=%0d status=%0d",
							results_seen, exp_res.inverse, exp_res.status,
							inverse, status);
					errors++;
				end
			end
		end
	end

	initial begin
		int unsigned   sel, g, x, y;
		logic [31:0]   rv, rm;
		logic [W-1:0]  v, m;

		queue_pair(0, 0);
		queue_pair(MAXV, 0);
		queue_pair(MAXV, 1);
		queue_pair(0, 1);
		queue_pair(3, 7);
		queue_pair(0, 7);
		queue_pair(14, 7);
		queue_pair(6, 9);
		queue_pair(10, 7);
		queue_pair(MAXV, MAXV);
		queue_pair(MAXV - 1, MAXV);
		queue_pair(1, MAXV);
		queue_pair(2, MAXV);
		queue_pair(1134903170, 1836311903);
		queue_pair(1836311903, 1134903170);
		queue_pair(MAXV, 2);
		queue_pair(1, 2);
		queue_pair(MAXV, 31'h4000_0000);
		queue_pair(31'h4000_0000, MAXV);
		queue_pair(12345, MAXV - 1);
		queue_pair(1, 3);
		queue_pair(2, 3);

		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(99);
			rv  = $urandom();
			rm  = $urandom();
			v   = rv[W-1:0];
			m   = rm[W-1:0];
			if (sel < 40) begin
			end else if (sel < 60) begin
				m = W'($urandom_range(1000, 2));
			end else if (sel < 75) begin
				if (m != 0)
					v = v % m;
			end else if (sel < 88) begin
				g = $urandom_range(1000, 2);
				x = $urandom_range(MAXV / g, 0);
				y = $urandom_range(MAXV / g, 1);
				v = W'(g * x);
				m = W'(g * y);
			end else if (sel < 95) begin
				v = W'($urandom_range(50, 0));
				m = W'($urandom_range(50, 0));
			end else begin
				m = W'($urandom_range(1, 0));
			end
			queue_pair(v, m);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pairs_pending.size() != 0 || inverse_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d transactions: %0d inverses, %0d with modulus one, %0d without inverse.",
			accepted_cnt, n_found, n_mod_one, n_none);
		$display("Output held off for %0d cycles once while input kept offering; %0d mismatches.",
			HOLDOFF, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("Timeout with %0d transactions pending and %0d results due",
			pairs_pending.size(), inverse_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
